### rtl/core/satl_pkg.sv
package satl_pkg;

  // Register indexes on the configuration port (byte address = 4 * index)
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_BITS = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WAY_COUNT   = 2'd2;

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  // Register reset values
  localparam logic [3:0] OFFSET_BITS_RST = 4'd6;
  localparam logic [2:0] INDEX_BITS_RST  = 3'd6;
  localparam logic [3:0] WAY_COUNT_RST   = 4'd4;

  // Parameter defaults
  localparam int MAX_SETS_DEF  = 64;
  localparam int MAX_WAYS_DEF  = 8;
  localparam int ADDR_BITS_DEF = 32;

  localparam int TAG_W = 32;
  localparam int CNT_W = 32;
  // The set index before wrapping holds at most seven bits (index_bits <= 7)
  localparam int RAW_IDX_W = 7;

  localparam logic ACT_ACCESS = 1'b0;
  localparam logic ACT_FLUSH  = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_LOOK
  } satl_state_t;

endpackage

### rtl/core/set_assoc_cache_tag_lookup_top.sv
// Tag directory of a set-associative cache.
// Input channel (in_valid/in_ready): one word per access, in_action selects a
// lookup (0) or a flush of the whole directory and both counters (1).
// Result channel (out_valid/out_ready): one word per input word, carrying the
// hit and eviction flags and both running counters after that access.
// Configuration: APB-style write/read of offset_bits (0x0), index_bits (0x4)
// and way_count (0x8); write only while no access is outstanding.
// Timing: an accepted word issues a read of its set row from the tag memory;
// once the result register is free, the lookup state compares all ways in
// parallel, writes the row back on a miss and loads the result register. A
// word is taken in the idle state and finished in the lookup state, so the
// next word is accepted in the cycle after the result is loaded.
// Stall: the result register holds while out_ready is low. A new word is still
// accepted, but its row update waits until the result register frees up.
// Reset: rst_n (synchronous) clears the per-row valid flags, the counters and
// the control state, and loads the register defaults. The memories are not
// swept: a row whose flag is clear reads as all ways invalid, tags zero.
// A flush clears the row flags the same way.
module set_assoc_cache_tag_lookup_top
  import satl_pkg::*;
#(
  parameter int MAX_SETS  = MAX_SETS_DEF,
  parameter int MAX_WAYS  = MAX_WAYS_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [31:0]           in_address,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_hit,
  output logic                  out_evicted,
  output logic [CNT_W-1:0]      out_hit_total,
  output logic [CNT_W-1:0]      out_miss_total,

  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WCNT_W  = $clog2(MAX_WAYS + 1) > 4 ? $clog2(MAX_WAYS + 1) : 4;
  localparam int ABITS   = (ADDR_BITS < 32) ? ADDR_BITS : 32;
  localparam logic [32:0] AMASK_W = (33'd1 << ABITS) - 33'd1;
  localparam int RAW_DEPTH = 1 << RAW_IDX_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [3:0] offset_bits_r;
  logic [2:0] index_bits_r;
  logic [3:0] way_count_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= OFFSET_BITS_RST;
      index_bits_r  <= INDEX_BITS_RST;
      way_count_r   <= WAY_COUNT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_OFFSET_BITS: offset_bits_r <= cfg_pwdata[3:0];
        REG_INDEX_BITS:  index_bits_r  <= cfg_pwdata[2:0];
        REG_WAY_COUNT:   way_count_r   <= cfg_pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_OFFSET_BITS: cfg_prdata = {28'd0, offset_bits_r};
      REG_INDEX_BITS:  cfg_prdata = {29'd0, index_bits_r};
      REG_WAY_COUNT:   cfg_prdata = {28'd0, way_count_r};
      default:         cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Address split: drop the block offset, take index, wrap it into the sets
  // ---------------------------------------------------------------------------
  logic [SET_W-1:0] set_lut [RAW_DEPTH];

  for (genvar g = 0; g < RAW_DEPTH; g++) begin : g_set_lut
    localparam int SET_VAL = g % MAX_SETS;
    assign set_lut[g] = SET_W'(SET_VAL);
  end

  logic [31:0]          addr_m;
  logic [31:0]          block;
  logic [RAW_IDX_W-1:0] idx_mask;
  logic [RAW_IDX_W-1:0] raw_idx;
  logic [SET_W-1:0]     set_in;
  logic [TAG_W-1:0]     tag_in;

  always_comb begin
    addr_m   = in_address & AMASK_W[31:0];
    block    = addr_m >> offset_bits_r;
    idx_mask = RAW_IDX_W'((8'd1 << index_bits_r) - 8'd1);
    raw_idx  = block[RAW_IDX_W-1:0] & idx_mask;
    set_in   = set_lut[raw_idx];
    tag_in   = TAG_W'(block >> index_bits_r);
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  satl_state_t state_r, state_nxt;
  logic        accept;
  logic        done;
  logic        out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    done      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        // Wait for a free result register before touching any state
        if (!out_valid_r || out_ready) begin
          done      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign accept = in_valid && in_ready;

  // Latched access
  logic             act_r;
  logic [SET_W-1:0] set_r;
  logic [TAG_W-1:0] tag_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      act_r <= in_action;
      set_r <= set_in;
      tag_r <= tag_in;
    end
  end

  // ---------------------------------------------------------------------------
  // Set memories: one row per set, all ways side by side
  // ---------------------------------------------------------------------------
  logic [MAX_WAYS-1:0][TAG_W-1:0] tag_mem [MAX_SETS];
  logic [MAX_WAYS-1:0]            vld_mem [MAX_SETS];
  logic [MAX_WAYS-1:0][TAG_W-1:0] tag_rd_r;
  logic [MAX_WAYS-1:0]            vld_rd_r;
  logic [MAX_WAYS-1:0][TAG_W-1:0] tag_wr;
  logic [MAX_WAYS-1:0]            vld_wr;
  logic                           mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tag_mem[set_r] <= tag_wr;
      vld_mem[set_r] <= vld_wr;
    end
    if (accept) begin
      tag_rd_r <= tag_mem[set_in];
      vld_rd_r <= vld_mem[set_in];
    end
  end

  // Row flags: a row never written since reset or flush reads as empty
  logic [MAX_SETS-1:0] row_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (done && act_r == ACT_FLUSH) begin
      row_vld_r <= '0;
    end else if (mem_we) begin
      row_vld_r[set_r] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Compare, choose the fill way, update
  // ---------------------------------------------------------------------------
  logic [WCNT_W-1:0]   ways_eff;
  logic [MAX_WAYS-1:0] row_vld;
  logic [MAX_WAYS-1:0] in_use;
  logic [MAX_WAYS-1:0] match;
  logic [MAX_WAYS-1:0] free_way;
  logic [MAX_WAYS-1:0] fill_sel;
  logic                found;
  logic                any_free;

  always_comb begin
    if (way_count_r == 4'd0) begin
      ways_eff = WCNT_W'(1);
    end else if (int'(way_count_r) > MAX_WAYS) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(way_count_r);
    end
  end

  always_comb begin
    row_vld  = row_vld_r[set_r] ? vld_rd_r : '0;
    fill_sel = '0;
    any_free = 1'b0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w]   = w < int'(ways_eff);
      match[w]    = in_use[w] && row_vld[w] && (tag_rd_r[w] == tag_r);
      free_way[w] = in_use[w] && !row_vld[w];
    end
    // Lowest-numbered free way wins
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (free_way[w] && !any_free) begin
        fill_sel[w] = 1'b1;
        any_free    = 1'b1;
      end
    end
    found = |match;
  end

  logic evict;

  always_comb begin
    evict = !found && !any_free;
    for (int w = 0; w < MAX_WAYS; w++) begin
      // Invalid rows read back zero tags
      tag_wr[w] = row_vld_r[set_r] ? tag_rd_r[w] : '0;
      vld_wr[w] = row_vld[w];
      if (fill_sel[w] || (evict && w == 0)) begin
        tag_wr[w] = tag_r;
        vld_wr[w] = 1'b1;
      end
    end
    mem_we = done && act_r == ACT_ACCESS && !found;
  end

  // Counters
  logic [CNT_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [CNT_W-1:0] miss_cnt_r, miss_cnt_nxt;

  always_comb begin
    hit_cnt_nxt  = hit_cnt_r;
    miss_cnt_nxt = miss_cnt_r;
    if (done) begin
      if (act_r == ACT_FLUSH) begin
        hit_cnt_nxt  = '0;
        miss_cnt_nxt = '0;
      end else if (found) begin
        hit_cnt_nxt  = hit_cnt_r + CNT_W'(1);
      end else begin
        miss_cnt_nxt = miss_cnt_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
    end else begin
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic             out_hit_r;
  logic             out_evicted_r;
  logic [CNT_W-1:0] out_hit_total_r;
  logic [CNT_W-1:0] out_miss_total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_hit_r        <= (act_r == ACT_ACCESS) && found;
      out_evicted_r    <= (act_r == ACT_ACCESS) && evict;
      out_hit_total_r  <= hit_cnt_nxt;
      out_miss_total_r <= miss_cnt_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_evicted    = out_evicted_r;
  assign out_hit_total  = out_hit_total_r;
  assign out_miss_total = out_miss_total_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef SYNTHESIS
  a_result_after_look : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_LOOK))
    else $error("result appeared without a lookup");

  a_hit_xor_evict : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_evicted_r))
    else $error("result flags both hit and eviction");

  a_flush_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (done && act_r == ACT_FLUSH) |=>
      (out_hit_total_r == '0 && out_miss_total_r == '0 && row_vld_r == '0))
    else $error("flush left counters or rows set");

  a_one_counter : assert property (@(posedge clk) disable iff (!rst_n)
    (done && act_r == ACT_ACCESS) |=>
      ((hit_cnt_r == $past(hit_cnt_r) + CNT_W'(1) && miss_cnt_r == $past(miss_cnt_r)) ||
       (miss_cnt_r == $past(miss_cnt_r) + CNT_W'(1) && hit_cnt_r == $past(hit_cnt_r))))
    else $error("access did not advance exactly one counter");
`endif

endmodule
